FILE: hw/rtl/rtfp_pkg.sv
// shared constants, types and slot decode helpers for the radar frame parser
package rtfp_pkg;

    localparam int FRAME_BYTES  = 30;
    localparam int TARGET_SLOTS = 3;
    localparam int SLOT_BYTES   = 8;
    localparam int HEADER_BYTES = 4;
    localparam int FILL_W       = $clog2(FRAME_BYTES + 1);
    localparam int SLOT_W       = 2;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] SYNC_BYTE [HEADER_BYTES] = '{8'hAA, 8'hFF, 8'h03, 8'h00};
    localparam logic [7:0] TAIL_BYTE0 = 8'h55;
    localparam logic [7:0] TAIL_BYTE1 = 8'hCC;
    localparam logic [15:0] SIGN_MASK = 16'h8000;
    localparam logic [15:0] X_BAD_RAW = 16'h7FC0;
    localparam logic [15:0] Y_BAD_RAW = 16'h0040;

    typedef enum logic [1:0] {
        F_IDLE,
        F_SCAN,
        F_EMIT
    } t_front_state;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SQX,
        B_SQY,
        B_ROOT,
        B_OUT
    } t_back_state;

    // one slot handed from the frame collector to the decoder
    typedef struct packed {
        logic [31:0]            frame_number;
        logic [SLOT_W-1:0]      slot_index;
        logic                   target_valid;
        logic [1:0]             valid_count;
        logic                   last_target;
        logic [SLOT_BYTES*8-1:0] slot_bytes;
    } t_slot_job;

    // slot is a real target: not all zero, x and y not a marker value
    function automatic logic slot_is_valid(input logic [SLOT_BYTES*8-1:0] b);
        logic [15:0] raw_x;
        logic [15:0] raw_y;
        logic        bad;
        raw_x = b[15:0];
        raw_y = b[31:16];
        bad = (b == '0) || (raw_x == X_BAD_RAW) || (raw_y == '0) || (raw_y == Y_BAD_RAW);
        return !bad;
    endfunction

    // sign-magnitude decode: top bit set gives the magnitude, else the negated raw value
    function automatic logic [15:0] sign_mag(input logic [15:0] raw);
        return raw[15] ? {1'b0, raw[14:0]} : 16'(-raw);
    endfunction

endpackage

FILE: hw/rtl/rtfp_channels.sv
// channel interfaces: received byte words in, target words out
interface rtfp_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] data_byte;

    modport source (output valid, operation, data_byte, input ready);
    modport sink   (input valid, operation, data_byte, output ready);
endinterface

interface rtfp_out_if;
    logic               valid;
    logic               ready;
    logic [31:0]        frame_number;
    logic [1:0]         slot_index;
    logic               target_valid;
    logic signed [15:0] x_mm;
    logic signed [15:0] y_mm;
    logic signed [15:0] velocity_cm_s;
    logic [15:0]        res_step_mm;
    logic [15:0]        range_mm;
    logic [1:0]         valid_count;
    logic               last_target;

    modport source (output valid, frame_number, slot_index, target_valid, x_mm, y_mm,
                    velocity_cm_s, res_step_mm, range_mm, valid_count, last_target,
                    input ready);
    modport sink   (input valid, frame_number, slot_index, target_valid, x_mm, y_mm,
                    velocity_cm_s, res_step_mm, range_mm, valid_count, last_target,
                    output ready);
endinterface

FILE: hw/rtl/radar_target_frame_parser_core.sv
// top level of the radar frame parser: collector, slot queue, decoder
//
//  channel    dir  word                        handshake
//  i_byte     in   operation, data_byte        valid/ready
//  o_target   out  one decoded target slot     valid/ready
//
//  a byte word is taken in idle, then scanned; a resync drops buffered bytes one at a time (up to 30)
//  a complete frame issues three slot words into a 4-deep queue, one per cycle while the queue has room
//  the decoder takes one slot word at a time: x square, y square, 16-step bit-pair root, output
//  reset: synchronous active low, buffer fill and frame counter cleared
//  the collector keeps taking bytes while the decoder waits on o_target.ready,
//  until a finished frame finds the queue full
module radar_target_frame_parser_core
    import rtfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    rtfp_in_if.sink     i_byte,
    rtfp_out_if.source  o_target
);

    t_slot_job push_job, pop_job;
    logic      push_valid, push_ready, pop_valid, pop_ready;

    // byte collection and frame checks
    rtfp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte      (i_byte),
        .o_job       (push_job),
        .o_job_valid (push_valid),
        .i_job_ready (push_ready)
    );

    // slot queue
    rtfp_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push_job),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .o_pop        (pop_job),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready)
    );

    // slot decode and distance
    rtfp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (pop_job),
        .i_job_valid (pop_valid),
        .o_job_ready (pop_ready),
        .o_target    (o_target)
    );

endmodule

FILE: hw/rtl/rtfp_front.sv
// frame collector: byte buffer, header resync, tail check, slot job issue
module rtfp_front
    import rtfp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    rtfp_in_if.sink    i_byte,
    output t_slot_job  o_job,
    output logic       o_job_valid,
    input  logic       i_job_ready
);

    logic [7:0]        r_buf [FRAME_BYTES];
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [31:0]       r_frame_cnt, n_frame_cnt;
    logic [SLOT_W-1:0] r_slot, n_slot;
    t_front_state      r_state, n_state;

    logic                    accept, is_full, prefix_ok, tail_ok, drop, store;
    logic [SLOT_BYTES*8-1:0] slot_data [TARGET_SLOTS];
    logic [TARGET_SLOTS-1:0] slot_ok;
    logic [1:0]              vcount;

    assign accept  = i_byte.valid && i_byte.ready;
    assign is_full = (r_fill == FILL_W'(FRAME_BYTES));
    assign tail_ok = (r_buf[FRAME_BYTES-2] == TAIL_BYTE0) && (r_buf[FRAME_BYTES-1] == TAIL_BYTE1);

    // header prefix over the bytes present
    always_comb begin
        prefix_ok = 1'b1;
        for (int k = 0; k < HEADER_BYTES; k++) begin
            if (FILL_W'(k) < r_fill && r_buf[k] != SYNC_BYTE[k]) prefix_ok = 1'b0;
        end
    end

    // slot views and validity
    always_comb begin
        vcount = '0;
        for (int s = 0; s < TARGET_SLOTS; s++) begin
            for (int b = 0; b < SLOT_BYTES; b++) begin
                slot_data[s][8*b +: 8] = r_buf[HEADER_BYTES + s*SLOT_BYTES + b];
            end
            slot_ok[s] = slot_is_valid(slot_data[s]);
            vcount = vcount + 2'(slot_ok[s]);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: begin
                if (accept && !i_byte.operation) n_state = F_SCAN;
            end
            F_SCAN: begin
                if (r_fill == '0) n_state = F_IDLE;
                else if (!prefix_ok) n_state = F_SCAN;
                else if (!is_full) n_state = F_IDLE;
                else if (tail_ok) n_state = F_EMIT;
            end
            F_EMIT: begin
                if (i_job_ready && r_slot == SLOT_W'(TARGET_SLOTS-1)) n_state = F_IDLE;
            end
            default: n_state = F_IDLE;
        endcase
    end

    // buffer control and outputs
    always_comb begin
        drop        = 1'b0;
        store       = 1'b0;
        n_fill      = r_fill;
        n_frame_cnt = r_frame_cnt;
        n_slot      = r_slot;
        o_job_valid = 1'b0;
        unique case (r_state)
            F_IDLE: begin
                if (accept) begin
                    if (i_byte.operation) n_fill = '0;
                    else begin
                        store = 1'b1;
                        drop  = is_full;
                        if (!is_full) n_fill = r_fill + 1'b1;
                    end
                end
            end
            F_SCAN: begin
                if (r_fill != '0) begin
                    if (!prefix_ok || (is_full && !tail_ok)) begin
                        drop   = 1'b1;
                        n_fill = r_fill - 1'b1;
                    end else if (is_full) begin
                        n_slot = '0;
                        if (r_frame_cnt != '1) n_frame_cnt = r_frame_cnt + 1'b1;
                    end
                end
            end
            F_EMIT: begin
                o_job_valid = 1'b1;
                if (i_job_ready) begin
                    n_slot = r_slot + 1'b1;
                    if (r_slot == SLOT_W'(TARGET_SLOTS-1)) n_fill = '0;
                end
            end
            default: ;
        endcase
    end

    assign i_byte.ready = (r_state == F_IDLE);

    // job payload for the current slot
    always_comb begin
        o_job.frame_number = r_frame_cnt;
        o_job.slot_index   = r_slot;
        o_job.target_valid = slot_ok[r_slot];
        o_job.valid_count  = vcount;
        o_job.last_target  = (r_slot == SLOT_W'(TARGET_SLOTS-1));
        o_job.slot_bytes   = slot_data[r_slot];
    end

    // byte buffer: drop shifts everything down one place
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < FRAME_BYTES; i++) begin
            if (drop) begin
                if (i == FRAME_BYTES-1) begin
                    if (store) r_buf[i] <= i_byte.data_byte;
                end else begin
                    r_buf[i] <= r_buf[i+1];
                end
            end else if (store && r_fill == FILL_W'(i)) begin
                r_buf[i] <= i_byte.data_byte;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= F_IDLE;
            r_fill      <= '0;
            r_frame_cnt <= '0;
            r_slot      <= '0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_frame_cnt <= n_frame_cnt;
            r_slot      <= n_slot;
        end
    end

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(FRAME_BYTES))
        else $error("fill count beyond frame length");
    a_emit_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == F_EMIT |-> is_full && tail_ok && prefix_ok)
        else $error("slot issue without a complete frame");
    a_cnt_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == F_EMIT |=> r_frame_cnt == $past(r_frame_cnt))
        else $error("frame counter moved while issuing slots");

endmodule

FILE: hw/rtl/rtfp_queue.sv
// short slot job queue between collector and decoder
module rtfp_queue
    import rtfp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_slot_job i_push,
    input  logic      i_push_valid,
    output logic      o_push_ready,
    output t_slot_job o_pop,
    output logic      o_pop_valid,
    input  logic      i_pop_ready
);

    t_slot_job           r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr, r_rd;
    logic [QPTR_W:0]     r_count;
    logic                push, pop;

    assign o_push_ready = (r_count != (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_pop        = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wr] <= i_push;
    end

    // pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) r_wr <= r_wr + 1'b1;
            if (pop)  r_rd <= r_rd + 1'b1;
            r_count <= r_count + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
        end
    end

endmodule

FILE: hw/rtl/rtfp_back.sv
// slot decoder: field decode, squares and bit-pair root for distance
module rtfp_back
    import rtfp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_slot_job i_job,
    input  logic      i_job_valid,
    output logic      o_job_ready,
    rtfp_out_if.source o_target
);

    t_back_state        r_state, n_state;
    logic [31:0]        r_frame;
    logic [SLOT_W-1:0]  r_slot;
    logic               r_valid, r_last;
    logic [1:0]         r_vcount;
    logic signed [15:0] r_x, r_y, r_sp;
    logic [15:0]        r_res;
    logic [31:0]        r_rem, r_root, r_bit;

    logic        load;
    logic [31:0] trial;
    logic [SLOT_BYTES*8-1:0] jb;

    assign jb    = i_job.slot_bytes;
    assign load  = (r_state == B_IDLE) && i_job_valid;
    assign trial = r_root + r_bit;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: if (i_job_valid) n_state = B_SQX;
            B_SQX:  n_state = B_SQY;
            B_SQY:  n_state = B_ROOT;
            B_ROOT: if (r_bit == 32'd1) n_state = B_OUT;
            B_OUT:  if (o_target.ready) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_job_ready             = (r_state == B_IDLE);
        o_target.valid          = (r_state == B_OUT);
        o_target.frame_number   = r_frame;
        o_target.slot_index     = r_slot;
        o_target.target_valid   = r_valid;
        o_target.x_mm           = r_x;
        o_target.y_mm           = r_y;
        o_target.velocity_cm_s  = r_sp;
        o_target.res_step_mm    = r_res;
        o_target.range_mm       = r_root[15:0];
        o_target.valid_count    = r_vcount;
        o_target.last_target    = r_last;
    end

    // datapath: invalid slots decode to zero, so the root is zero too
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            B_IDLE: begin
                if (load) begin
                    r_frame  <= i_job.frame_number;
                    r_slot   <= i_job.slot_index;
                    r_valid  <= i_job.target_valid;
                    r_last   <= i_job.last_target;
                    r_vcount <= i_job.valid_count;
                    r_x      <= i_job.target_valid ? sign_mag(jb[15:0]) : '0;
                    r_y      <= i_job.target_valid ? (jb[31:16] ^ SIGN_MASK) : '0;
                    r_sp     <= i_job.target_valid ? sign_mag(jb[47:32]) : '0;
                    r_res    <= i_job.target_valid ? jb[63:48] : '0;
                end
            end
            B_SQX: r_rem <= 32'(r_x) * 32'(r_x);
            B_SQY: begin
                r_rem  <= r_rem + 32'(r_y) * 32'(r_y);
                r_root <= '0;
                r_bit  <= 32'd1 << 30;
            end
            B_ROOT: begin
                if (r_rem >= trial) begin
                    r_rem  <= r_rem - trial;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            B_OUT: ;
            default: ;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= B_IDLE;
        else          r_state <= n_state;
    end

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_target.valid && !o_target.target_valid |->
            o_target.x_mm == '0 && o_target.y_mm == '0 && o_target.velocity_cm_s == '0 &&
            o_target.res_step_mm == '0 && o_target.range_mm == '0)
        else $error("invalid slot carries nonzero fields");
    a_bit_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == B_ROOT |-> $onehot(r_bit))
        else $error("root step bit lost");
    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_target.valid |-> r_root <= 32'd46341)
        else $error("distance out of range");

endmodule

FILE: dv/radar_target_frame_parser_core_tb.sv
// testbench for the radar frame parser: framed and noisy byte words, target words checked
module radar_target_frame_parser_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rtfp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 700;
    localparam int HOLD_AT_WORD = 120;

    typedef struct {
        bit         operation;
        logic [7:0] data_byte;
    } t_byte_word;

    typedef struct {
        logic [31:0]        frame_number;
        logic [1:0]         slot_index;
        logic               target_valid;
        logic signed [15:0] x_mm;
        logic signed [15:0] y_mm;
        logic signed [15:0] velocity_cm_s;
        logic [15:0]        res_step_mm;
        logic [15:0]        range_mm;
        logic [1:0]         valid_count;
        logic               last_target;
    } t_target_word;

    logic clk;
    logic rst_n;

    rtfp_in_if  byte_if ();
    rtfp_out_if tgt_if ();

    radar_target_frame_parser_core dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_byte   (byte_if),
        .o_target (tgt_if)
    );

    t_byte_word   pending_bytes[$];
    t_target_word expected_targets[$];
    logic [7:0]   rx_buf[$];
    logic [31:0]  frame_cnt = '0;

    int errors;
    int cycles;
    int words_sent;
    int words_seen;
    int frames_seen;
    int valid_seen;
    int flushes_sent;
    int frames_planned;

    // clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // floor square root, bit-pair method
    function automatic logic [15:0] int_root(input longint v);
        longint rem;
        longint root;
        longint bitv;
        rem = v;
        root = 0;
        bitv = 64'd1 << 32;
        while (bitv > rem) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= root + bitv) begin
                rem = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root[15:0];
    endfunction

    function automatic int sm_decode(input logic [7:0] lo, input logic [7:0] hi);
        int raw;
        raw = {hi, lo};
        return hi[7] ? raw - 32768 : -raw;
    endfunction

    // decode a complete frame held in rx_buf into three target words
    function automatic void decode_frame();
        t_target_word tw[TARGET_SLOTS];
        logic [7:0]   p[SLOT_BYTES];
        int           x, y, sp;
        int           nvalid;
        bit           nonzero;
        nvalid = 0;
        if (frame_cnt != 32'hFFFF_FFFF) frame_cnt = frame_cnt + 1;
        for (int s = 0; s < TARGET_SLOTS; s++) begin
            nonzero = 1'b0;
            for (int i = 0; i < SLOT_BYTES; i++) begin
                p[i] = rx_buf[HEADER_BYTES + s*SLOT_BYTES + i];
                if (p[i] != 8'h00) nonzero = 1'b1;
            end
            tw[s] = '{default: '0};
            tw[s].frame_number = frame_cnt;
            tw[s].slot_index = 2'(s);
            tw[s].last_target = (s == TARGET_SLOTS - 1);
            x = sm_decode(p[0], p[1]);
            y = int'({p[3], p[2]}) - 32768;
            sp = sm_decode(p[4], p[5]);
            if (nonzero && x != -32768 && x != -32704 && y != -32768 && y != -32704) begin
                tw[s].target_valid = 1'b1;
                tw[s].x_mm = 16'(x);
                tw[s].y_mm = 16'(y);
                tw[s].velocity_cm_s = 16'(sp);
                tw[s].res_step_mm = {p[7], p[6]};
                tw[s].range_mm = int_root(longint'(x)*x + longint'(y)*y);
                nvalid++;
            end
        end
        for (int s = 0; s < TARGET_SLOTS; s++) begin
            tw[s].valid_count = 2'(nvalid);
            expected_targets.push_back(tw[s]);
        end
    endfunction

    // collector behavior for one accepted byte word
    function automatic void predict_word(input t_byte_word w);
        int  n;
        bit  hdr_ok;
        if (w.operation) begin
            rx_buf.delete();
            return;
        end
        if (rx_buf.size() >= FRAME_BYTES) void'(rx_buf.pop_front());
        rx_buf.push_back(w.data_byte);
        while (rx_buf.size() > 0) begin
            n = rx_buf.size() < HEADER_BYTES ? rx_buf.size() : HEADER_BYTES;
            hdr_ok = 1'b1;
            for (int i = 0; i < n; i++)
                if (rx_buf[i] != SYNC_BYTE[i]) hdr_ok = 1'b0;
            if (!hdr_ok) begin
                void'(rx_buf.pop_front());
                continue;
            end
            if (rx_buf.size() < FRAME_BYTES) return;
            if (rx_buf[FRAME_BYTES-2] == TAIL_BYTE0 && rx_buf[FRAME_BYTES-1] == TAIL_BYTE1) begin
                decode_frame();
                rx_buf.delete();
                return;
            end
            void'(rx_buf.pop_front());
        end
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        errors++;
        $display("word %0d: %s got %0h expected %0h", words_seen, what, got, want);
    endtask

    // stimulus builders
    function automatic void add_byte(input logic [7:0] b);
        pending_bytes.push_back('{1'b0, b});
    endfunction

    function automatic void add_flush();
        pending_bytes.push_back('{1'b1, 8'($urandom)});
        flushes_sent++;
    endfunction

    function automatic void add_slot(input int kind);
        logic [7:0] s[SLOT_BYTES];
        foreach (s[i]) s[i] = 8'($urandom);
        case (kind)
            0: foreach (s[i]) s[i] = 8'h00;
            1: begin s[0] = 8'hC0; s[1] = 8'h7F; end
            2: begin s[2] = 8'h00; s[3] = 8'h00; end
            3: begin s[2] = 8'h40; s[3] = 8'h00; end
            4: begin s[0] = 8'hFF; s[1] = 8'hFF; s[2] = 8'hFF; s[3] = 8'hFF; end
            5: begin s[0] = 8'hFF; s[1] = 8'h7F; s[2] = 8'h01; s[3] = 8'h00; end
            6: begin s[0] = 8'h00; s[1] = 8'h80; s[4] = 8'h00; s[5] = 8'h80; end
            7: begin s[0] = 8'h01; s[1] = 8'h00; s[4] = 8'hFF; s[5] = 8'h7F; end
            default: ;
        endcase
        foreach (s[i]) add_byte(s[i]);
    endfunction

    function automatic void add_frame(input int k0, input int k1, input int k2, input bit good);
        foreach (SYNC_BYTE[i]) add_byte(SYNC_BYTE[i]);
        add_slot(k0);
        add_slot(k1);
        add_slot(k2);
        add_byte(good ? TAIL_BYTE0 : 8'($urandom_range(0, 84)));
        add_byte(TAIL_BYTE1);
        if (good) frames_planned++;
    endfunction

    function automatic int rand_kind();
        return $urandom_range(0, 3) == 0 ? $urandom_range(0, 7) : 8;
    endfunction

    // byte word driver
    int  gap_left;
    bit  no_gap_mode;
    always @(posedge clk) begin
        if (!rst_n) begin
            byte_if.valid <= 1'b0;
            byte_if.operation <= 1'b0;
            byte_if.data_byte <= 8'h00;
            gap_left <= 0;
        end else if (!byte_if.valid || byte_if.ready) begin
            if (byte_if.valid) begin
                predict_word('{byte_if.operation, byte_if.data_byte});
                words_sent++;
            end
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                byte_if.valid <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
                t_byte_word w;
                w = pending_bytes.pop_front();
                byte_if.valid <= 1'b1;
                byte_if.operation <= w.operation;
                byte_if.data_byte <= w.data_byte;
                if (words_sent % 60 == 0) no_gap_mode <= $urandom_range(0, 2) == 0;
                gap_left <= no_gap_mode ? 0 : $urandom_range(0, 13);
            end else begin
                byte_if.valid <= 1'b0;
            end
        end
    end

    // one long receiver hold-off so the slot queue fills and input backs up
    int  hold_left;
    bit  hold_done;
    always @(posedge clk) begin
        if (!rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && words_sent >= HOLD_AT_WORD) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // target word monitor and receiver stalls
    int  stall_left;
    always @(posedge clk) begin
        if (!rst_n) begin
            tgt_if.ready <= 1'b0;
            stall_left <= 0;
        end else begin
            int st;
            st = stall_left;
            if (tgt_if.valid && tgt_if.ready) begin
                words_seen++;
                if (expected_targets.size() == 0) begin
                    report_mismatch("target word with none expected", 0, 0);
                end else begin
                    t_target_word e;
                    e = expected_targets.pop_front();
                    if (tgt_if.frame_number !== e.frame_number)
                        report_mismatch("frame_number", tgt_if.frame_number, e.frame_number);
                    if (tgt_if.slot_index !== e.slot_index)
                        report_mismatch("slot_index", tgt_if.slot_index, e.slot_index);
                    if (tgt_if.target_valid !== e.target_valid)
                        report_mismatch("target_valid", tgt_if.target_valid, e.target_valid);
                    if (tgt_if.x_mm !== e.x_mm)
                        report_mismatch("x_mm", tgt_if.x_mm, e.x_mm);
                    if (tgt_if.y_mm !== e.y_mm)
                        report_mismatch("y_mm", tgt_if.y_mm, e.y_mm);
                    if (tgt_if.velocity_cm_s !== e.velocity_cm_s)
                        report_mismatch("velocity_cm_s", tgt_if.velocity_cm_s,
                                        e.velocity_cm_s);
                    if (tgt_if.res_step_mm !== e.res_step_mm)
                        report_mismatch("res_step_mm", tgt_if.res_step_mm, e.res_step_mm);
                    if (tgt_if.range_mm !== e.range_mm)
                        report_mismatch("range_mm", tgt_if.range_mm, e.range_mm);
                    if (tgt_if.valid_count !== e.valid_count)
                        report_mismatch("valid_count", tgt_if.valid_count, e.valid_count);
                    if (tgt_if.last_target !== e.last_target)
                        report_mismatch("last_target", tgt_if.last_target, e.last_target);
                    if (e.target_valid) valid_seen++;
                    if (e.last_target) frames_seen++;
                end
                st = no_gap_mode ? 0 : $urandom_range(0, 13);
            end
            if ((!hold_done && words_sent >= HOLD_AT_WORD) || hold_left > 0) begin
                tgt_if.ready <= 1'b0;
                stall_left <= st;
            end else if (st > 0) begin
                stall_left <= st - 1;
                tgt_if.ready <= 1'b0;
            end else begin
                stall_left <= 0;
                tgt_if.ready <= 1'b1;
            end
        end
    end

    // run limit
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("radar_target_frame_parser_core: mismatch");
            $finish;
        end
    end

    initial begin
        flushes_sent = 0;
        frames_planned = 0;
        rst_n = 1'b0;

        // directed: extremes, markers, flush, bad tail, false header starts
        add_frame(0, 0, 0, 1'b1);
        add_frame(4, 5, 6, 1'b1);
        add_frame(1, 2, 3, 1'b1);
        add_frame(7, 8, 8, 1'b0);
        add_byte(8'hAA); add_byte(8'hFF); add_byte(8'h03);
        add_flush();
        add_byte(8'hAA); add_byte(8'hAA); add_byte(8'hFF);
        add_frame(8, 7, 8, 1'b1);

        // random: mostly framed traffic, some noise, bad tails and cut frames
        while (pending_bytes.size() < 370 || frames_planned < 8) begin
            case ($urandom_range(0, 9))
                0: repeat ($urandom_range(1, 6)) add_byte(8'($urandom));
                1: add_frame(rand_kind(), rand_kind(), rand_kind(), 1'b0);
                2: begin
                    foreach (SYNC_BYTE[i]) add_byte(SYNC_BYTE[i]);
                    repeat ($urandom_range(0, 25)) add_byte(8'($urandom));
                    add_flush();
                end
                default: begin
                    if ($urandom_range(0, 3) == 0) add_byte(SYNC_BYTE[0]);
                    add_frame(rand_kind(), rand_kind(), rand_kind(), 1'b1);
                end
            endcase
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_bytes.size() > 0 || byte_if.valid) @(posedge clk);
        while (expected_targets.size() > 0) @(posedge clk);
        repeat (200) @(posedge clk);

        $display("sent %0d byte words (%0d flushes), checked %0d target words",
                 words_sent, flushes_sent, words_seen);
        $display("covered %0d frames, %0d valid targets", frames_seen, valid_seen);
        if (errors == 0 && expected_targets.size() == 0) begin
            $display("radar_target_frame_parser_core: match");
        end else begin
            $display("radar_target_frame_parser_core: mismatch");
        end
        $finish;
    end

endmodule
